/* rtl/core/dwms_pkg.sv */
// Package: sizes, operation and status codes, controller states, request and response types for the deque.
package dwms_pkg;

  // Store geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW         = $clog2(DEPTH + 1);

  // Operation codes
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_SEARCH     = 2'd3
  } dwms_kind_e;

  // Status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } dwms_status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_SEARCH
  } dwms_state_e;

  typedef struct packed {
    dwms_kind_e         kind;
    logic signed [31:0] value;
  } dwms_req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic               found;
    dwms_status_e       status;
    logic [4:0]         occupancy;
  } dwms_rsp_t;

endpackage

/* rtl/core/deque_with_membership_search.sv */
// Top level: ring-buffer deque controller with a linear membership search.
//
// Usage:
//   A request (operation kind and data word on req_i) is taken at a rising
//   edge where start_i is high and busy_o is low. Each request yields one
//   response on rsp_o, marked by done_o for exactly one cycle; the receiver
//   cannot stall it and must take it in that cycle.
// Timing:
//   Push front / push back: one memory write; response in the cycle after
//     the request, busy_o stays low, so a new request may follow at once.
//   Pop front: one memory read; busy_o high for one cycle, response
//     registered in ST_POP_WAIT from the read data of the RAM.
//   Search: walks the stored entries from the front, one memory read per
//     cycle, and stops at the first match or at the last entry; the response
//     is registered from the compare of that entry.
//   Pop or search on empty store, push on full store: response next cycle.
//   Pops and searches are paced by the single registered read port of the RAM.
// Reset:
//   rst_ni clears the state, the front pointer, the entry count and done_o;
//   the memory content is not cleared and needs no clearing pass.
module deque_with_membership_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  dwms_pkg::dwms_req_t req_i,
  output logic               done_o,
  output dwms_pkg::dwms_rsp_t rsp_o
);

  import dwms_pkg::*;

  // Low five bits of an entry count
  function automatic logic [4:0] occ5(input logic [CW-1:0] c);
    logic [CW+4:0] e;
    e = {5'b0, c};
    return e[4:0];
  endfunction

  // Ring position front + offset, offset at most DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dwms_state_e          state_q, state_d;
  logic [AW-1:0]        front_q, front_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                 done_q, done_d;
  dwms_rsp_t            rsp_q, rsp_d;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                   accept, full, empty, hit, last;
  logic [AW-1:0]          front_dec;
  logic [DATA_WIDTH+31:0] value_ext;
  logic [DATA_WIDTH+31:0] rdata_ext;
  logic [DATA_WIDTH-1:0]  in_word;

  // Status terms
  assign accept    = start_i && (state_q == ST_IDLE);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign hit       = (mem_rdata == word_q);
  assign last      = (idx_q == (count_q - CW'(1)));
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : (front_q - AW'(1));
  assign value_ext = {{DATA_WIDTH{1'b0}}, req_i.value};
  assign in_word   = value_ext[DATA_WIDTH-1:0];
  assign rdata_ext = {32'b0, mem_rdata};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_POP_FRONT && !empty) begin
            state_d = ST_POP_WAIT;
          end else if (req_i.kind == KIND_SEARCH && !empty) begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_POP_WAIT: state_d = ST_IDLE;
      ST_SEARCH: begin
        if (hit || last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory controls, pointer updates and response
  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    word_d    = word_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = front_q;
    mem_re    = 1'b0;
    mem_raddr = front_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d          = 1'b1;
          rsp_d.data_out  = '0;
          rsp_d.found     = 1'b0;
          rsp_d.status    = STATUS_OK;
          word_d          = in_word;
          case (req_i.kind)
            KIND_PUSH_FRONT: begin
              if (full) begin
                rsp_d.status = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                front_d   = front_dec;
                count_d   = count_q + CW'(1);
              end
            end
            KIND_PUSH_BACK: begin
              if (full) begin
                rsp_d.status = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ring_add(front_q, count_q);
                count_d   = count_q + CW'(1);
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                rsp_d.status = STATUS_EMPTY;
              end else begin
                // answer after the read returns
                done_d = 1'b0;
                mem_re = 1'b1;
              end
            end
            default: begin
              if (!empty) begin
                done_d = 1'b0;
                mem_re = 1'b1;
                idx_d  = '0;
              end
            end
          endcase
          rsp_d.occupancy = occ5(count_d);
        end
      end
      ST_POP_WAIT: begin
        done_d          = 1'b1;
        front_d         = ring_add(front_q, CW'(1));
        count_d         = count_q - CW'(1);
        rsp_d.data_out  = $signed(rdata_ext[31:0]);
        rsp_d.occupancy = occ5(count_d);
      end
      ST_SEARCH: begin
        if (hit || last) begin
          done_d          = 1'b1;
          rsp_d.found     = hit;
          rsp_d.occupancy = occ5(count_q);
        end else begin
          // fetch the next entry from the front
          mem_re    = 1'b1;
          mem_raddr = ring_add(front_q, idx_q + CW'(1));
          idx_d     = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    word_q <= word_d;
    rsp_q  <= rsp_d;
  end

  dwms_ram #(
    .Depth (DEPTH),
    .Width (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (word_d),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // Entry count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // A push is answered in the next cycle
  a_push_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.kind == KIND_PUSH_FRONT || req_i.kind == KIND_PUSH_BACK)
    |=> done_o)
    else $error("push not answered in one cycle");

  // No response while a pop or search is still in flight
  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("response while busy");

  // An empty-pop response reports an empty store
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == STATUS_EMPTY) |-> (rsp_o.occupancy == 5'd0))
    else $error("empty status with nonzero occupancy");

  // A hit only comes from a search, which always reports ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.found |-> (rsp_o.status == STATUS_OK) && (rsp_o.data_out == 0))
    else $error("found flag with bad status or data");
`endif

endmodule

/* rtl/core/dwms_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module dwms_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/deque_with_membership_search_tb.sv */
// Testbench for the deque with membership search: directed table, then random requests.
`timescale 1ns / 100ps

module deque_with_membership_search_tb;
  import dwms_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned RANDOM_COUNT = 1080;
  localparam int unsigned MAX_GAP      = 60;

  // One row of the directed table; fixed_rsp is used when has_fixed is set
  typedef struct packed {
    dwms_req_t req;
    logic      has_fixed;
    dwms_rsp_t fixed_rsp;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  dwms_req_t req_i;
  logic      done_o;
  dwms_rsp_t rsp_o;

  // Shadow copy of the deque
  logic [DATA_WIDTH-1:0] deque_words [DEPTH];
  int unsigned           deque_head;
  int unsigned           deque_fill;

  dwms_rsp_t   pending_responses [$];
  stim_row_t   directed_rows [$];
  logic        use_fixed;
  dwms_rsp_t   fixed_rsp;
  int unsigned fail_count;
  int unsigned stall_cycles;
  int unsigned push_pct;

  deque_with_membership_search u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one request to the shadow deque and return the response it should give
  function automatic dwms_rsp_t deque_next_response(dwms_req_t req);
    dwms_rsp_t rsp;
    rsp = '0;
    rsp.status = STATUS_OK;
    case (req.kind)
      KIND_PUSH_FRONT: begin
        if (deque_fill >= DEPTH) begin
          rsp.status = STATUS_FULL;
        end else begin
          deque_head = (deque_head + DEPTH - 1) % DEPTH;
          deque_words[deque_head] = req.value;
          deque_fill++;
        end
      end
      KIND_PUSH_BACK: begin
        if (deque_fill >= DEPTH) begin
          rsp.status = STATUS_FULL;
        end else begin
          deque_words[(deque_head + deque_fill) % DEPTH] = req.value;
          deque_fill++;
        end
      end
      KIND_POP_FRONT: begin
        if (deque_fill == 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          rsp.data_out = deque_words[deque_head];
          deque_head = (deque_head + 1) % DEPTH;
          deque_fill--;
        end
      end
      default: begin
        // search only the live entries, front to back
        for (int unsigned i = 0; i < deque_fill; i++) begin
          if (deque_words[(deque_head + i) % DEPTH] == req.value) rsp.found = 1'b1;
        end
      end
    endcase
    rsp.occupancy = 5'(deque_fill);
    return rsp;
  endfunction

  function automatic stim_row_t make_row(dwms_kind_e kind, logic [31:0] value, logic has_fixed,
                                         dwms_status_e status, logic [4:0] occupancy);
    stim_row_t row;
    row = '0;
    row.req.kind            = kind;
    row.req.value           = value;
    row.has_fixed           = has_fixed;
    row.fixed_rsp.status    = status;
    row.fixed_rsp.occupancy = occupancy;
    return row;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] word;
    case ($urandom_range(7))
      0:       word = 32'h0000_0000;
      1:       word = 32'hffff_ffff;
      2:       word = 32'h8000_0000;
      3:       word = 32'h7fff_ffff;
      4, 5:    word = $urandom_range(7);
      default: word = $urandom;
    endcase
    return word;
  endfunction

  // Random request, biased by push_pct so the fill level sweeps between empty and full
  function automatic dwms_req_t random_request();
    dwms_req_t req;
    req.value = random_word();
    if ($urandom_range(99) < 20) begin
      req.kind = KIND_SEARCH;
      // half the time, if the deque holds entries, look for a word that is present
      if (deque_fill > 0 && $urandom_range(1) == 1)
        req.value = deque_words[(deque_head + $urandom_range(deque_fill - 1)) % DEPTH];
    end else if ($urandom_range(99) < push_pct) begin
      req.kind = ($urandom_range(1) == 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
    end else begin
      req.kind = KIND_POP_FRONT;
    end
    return req;
  endfunction

  function automatic void check_response(dwms_rsp_t exp_rsp, dwms_rsp_t act_rsp);
    if (act_rsp.data_out !== exp_rsp.data_out) begin
      $error("data_out: expected %h, got %h", exp_rsp.data_out, act_rsp.data_out);
      fail_count++;
    end
    if (act_rsp.found !== exp_rsp.found) begin
      $error("found: expected %b, got %b", exp_rsp.found, act_rsp.found);
      fail_count++;
    end
    if (act_rsp.status !== exp_rsp.status) begin
      $error("status: expected %0d, got %0d", exp_rsp.status, act_rsp.status);
      fail_count++;
    end
    if (act_rsp.occupancy !== exp_rsp.occupancy) begin
      $error("occupancy: expected %0d, got %0d", exp_rsp.occupancy, act_rsp.occupancy);
      fail_count++;
    end
  endfunction

  // Send one request (table row, or random if row < 0) after a random idle gap
  task automatic issue_request(input int unsigned idle_pct, input int row);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    if (row >= 0) begin
      req_i     <= directed_rows[row].req;
      use_fixed  = directed_rows[row].has_fixed;
      fixed_rsp  = directed_rows[row].fixed_rsp;
    end else begin
      req_i     <= random_request();
      use_fixed  = 1'b0;
    end
    start_i <= 1'b1;
    // hold the request until the block takes it
    do @(posedge clk_i); while (busy_o);
  endtask

  // Request/response monitor and stall watchdog
  always @(posedge clk_i) begin : monitor_proc
    dwms_rsp_t exp_rsp;
    logic      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        exp_rsp = deque_next_response(req_i);
        if (use_fixed) exp_rsp = fixed_rsp;
        pending_responses.push_back(exp_rsp);
        moved = 1'b1;
      end
      if (done_o) begin
        moved = 1'b1;
        if (pending_responses.size() == 0) begin
          $error("response with no request pending");
          fail_count++;
        end else begin
          check_response(pending_responses.pop_front(), rsp_o);
        end
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("deque_with_membership_search regression: fail");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus_proc
    int unsigned idle_pct;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    use_fixed    = 1'b0;
    fixed_rsp    = '0;
    fail_count   = 0;
    stall_cycles = 0;
    push_pct     = 50;
    deque_head   = 0;
    deque_fill   = 0;
    for (int i = 0; i < DEPTH; i++) deque_words[i] = '0;

    // Empty store, fill to the brim with extreme words, overflow, search, drain a little
    directed_rows.push_back(make_row(KIND_POP_FRONT,  32'h0000_0000, 1'b1, STATUS_EMPTY, 5'd0));
    directed_rows.push_back(make_row(KIND_SEARCH,     32'h0000_0000, 1'b1, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'h7fff_ffff, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h8000_0000, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'hffff_ffff, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h0000_0000, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'h0000_0001, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h5555_5555, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'haaaa_aaaa, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h8000_0001, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'h1234_5678, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h0000_ffff, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'hffff_0000, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h0f0f_0f0f, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'hf0f0_f0f0, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h3333_3333, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'hcccc_cccc, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h7fff_ffff, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_PUSH_BACK,  32'h0000_0002, 1'b1, STATUS_FULL,  5'd16));
    directed_rows.push_back(make_row(KIND_PUSH_FRONT, 32'hffff_fffe, 1'b1, STATUS_FULL,  5'd16));
    directed_rows.push_back(make_row(KIND_SEARCH,     32'h8000_0000, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_SEARCH,     32'h0000_0002, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_SEARCH,     32'h7fff_ffff, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_POP_FRONT,  32'h0000_0000, 1'b0, STATUS_OK,    5'd0));
    directed_rows.push_back(make_row(KIND_POP_FRONT,  32'hffff_ffff, 1'b0, STATUS_OK,    5'd0));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) issue_request(15, i);

    // Random part: sender idles lightly, then heavily, then not at all
    for (int unsigned n = 0; n < RANDOM_COUNT; n++) begin
      if (n < RANDOM_COUNT / 3)          idle_pct = 15;
      else if (n < 2 * RANDOM_COUNT / 3) idle_pct = 82;
      else                               idle_pct = 0;
      // change the push bias every 40 requests to sweep full and empty
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      issue_request(idle_pct, -1);
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // Wait out outstanding responses, then keep watching for strays
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("deque_with_membership_search regression: pass");
    end else begin
      $display("deque_with_membership_search regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dwms_pkg.sv
rtl/core/dwms_ram.sv
rtl/core/deque_with_membership_search.sv
tb/deque_with_membership_search_tb.sv
